[hw/rtl/tllcd_pkg.sv]
// Shared constants and control types for the terminated line to LCD block.
`timescale 1ns / 1ps
`default_nettype none

package tllcd_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned FILL_W          = 6;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 8;
  localparam int unsigned STORE_DEPTH_DEF = 64;

  localparam logic [DATA_W-1:0] LCD_SET_ADDR  = 8'h80;
  localparam logic [DATA_W-1:0] TERM_RESET    = 8'd35;
  localparam logic [FILL_W-1:0] MAX_LEN_RESET = 6'd50;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 1'd1;

  // Controller to datapath
  typedef struct packed {
    logic accept_en;
    logic ld_cmd;
    logic rd_issue;
    logic ld_data;
  } tllcd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_run;
    logic slot_free;
    logic run_empty;
    logic ptr_last;
  } tllcd_sts_t;

endpackage

`default_nettype wire

[hw/rtl/tllcd_in_if.sv]
// Input channel carrying one received byte per request.
`timescale 1ns / 1ps
`default_nettype none

interface tllcd_in_if import tllcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/tllcd_out_if.sv]
// Result channel carrying one LCD bus write per request.
`timescale 1ns / 1ps
`default_nettype none

interface tllcd_out_if import tllcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_data;
  logic [DATA_W-1:0] lcd_value;
  logic              last_of_run;

  modport source (output valid, output is_data, output lcd_value, output last_of_run,
                  input ready);
  modport sink (input valid, input is_data, input lcd_value, input last_of_run,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/tllcd_ctrl.sv]
// Sequencing state machine for line capture and display runs.
`timescale 1ns / 1ps
`default_nettype none

module tllcd_ctrl import tllcd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tllcd_sts_t sts,
  output tllcd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMD  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (sts.start_run) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (sts.slot_free) begin
          cmd.ld_cmd = 1'b1;
          state_nxt  = sts.run_empty ? S_IDLE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DATA;
      end
      S_DATA: begin
        if (sts.slot_free) begin
          cmd.ld_data = 1'b1;
          state_nxt   = sts.ptr_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tllcd_dp.sv]
// Line store, fill count, read pointer, settings and output register.
`timescale 1ns / 1ps
`default_nettype none

module tllcd_dp import tllcd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tllcd_cmd_t            cmd,
  output tllcd_sts_t                 sts,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  input  wire logic [DATA_W-1:0]     in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_is_data,
  output logic [DATA_W-1:0]          out_lcd_value,
  output logic                       out_last_of_run
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [8:0]  DEPTH_W9 = 9'(STORE_DEPTH);

  logic [DATA_W-1:0] store_mem [STORE_DEPTH];

  logic [DATA_W-1:0] term_r;
  logic [FILL_W-1:0] max_len_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] rd_ptr_r;
  logic [FILL_W-1:0] rd_ptr_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_is_data_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;

  logic [8:0]        limit9;
  logic              full;
  logic              accept;
  logic              nonzero;
  logic              is_term;
  logic              do_store;
  logic [8:0]        wr_addr9;
  logic [8:0]        rd_addr9;
  logic [FILL_W:0]   ptr_inc;

  // Effective limit is the smaller of the setting and the store depth
  always_comb begin
    if ({3'b000, max_len_r} > DEPTH_W9) begin
      limit9 = DEPTH_W9;
    end else begin
      limit9 = {3'b000, max_len_r};
    end
  end

  assign full     = ({3'b000, fill_r} >= limit9);
  assign accept   = in_valid & cmd.accept_en;
  assign nonzero  = (in_rx_byte != '0);
  assign is_term  = (in_rx_byte == term_r);
  assign do_store = accept & nonzero & !is_term & !full;
  assign wr_addr9 = {3'b000, fill_r};
  assign rd_addr9 = {3'b000, rd_ptr_r};
  assign ptr_inc  = {1'b0, rd_ptr_r} + 7'd1;

  assign sts.start_run = accept & nonzero & is_term & !full;
  assign sts.slot_free = !out_valid_r | out_ready;
  assign sts.run_empty = (fill_r == '0);
  assign sts.ptr_last  = (ptr_inc == {1'b0, fill_r});

  always_comb begin
    fill_nxt = fill_r;
    if (do_store) begin
      fill_nxt = fill_r + 6'd1;
    end else if (accept & nonzero & full) begin
      fill_nxt = '0;
    end else if (cmd.ld_data & sts.ptr_last) begin
      fill_nxt = '0;
    end
  end

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.ld_cmd) begin
      rd_ptr_nxt = '0;
    end else if (cmd.ld_data) begin
      rd_ptr_nxt = ptr_inc[FILL_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_cmd | cmd.ld_data) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      store_mem[wr_addr9[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= store_mem[rd_addr9[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r      <= TERM_RESET;
      max_len_r   <= MAX_LEN_RESET;
      fill_r      <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_TERMINATOR) begin
        term_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_MAX_LEN) begin
        max_len_r <= cfg_wdata[FILL_W-1:0];
      end
      fill_r      <= fill_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_cmd) begin
      out_is_data_r <= 1'b0;
      out_value_r   <= LCD_SET_ADDR;
      out_last_r    <= sts.run_empty;
    end else if (cmd.ld_data) begin
      out_is_data_r <= 1'b1;
      out_value_r   <= rd_data_r;
      out_last_r    <= sts.ptr_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_data     = out_is_data_r;
  assign out_lcd_value   = out_value_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_cmd || cmd.ld_data) |-> (!out_valid_r || out_ready))
    else $error("output register loaded while still holding a request");

  a_read_written_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (rd_ptr_r < fill_r))
    else $error("line store read beyond the fill count");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_data && sts.ptr_last) |=> (fill_r == '0))
    else $error("fill count not cleared at end of run");
`endif

endmodule

`default_nettype wire

[hw/rtl/terminated_line_to_char_lcd_core.sv]
// Top level of the terminated line to character LCD block.
`timescale 1ns / 1ps
`default_nettype none

// Collects received bytes into a line store and, when the terminator byte
// arrives, plays the line out as character-LCD bus writes: first a set
// address command (0x80, is_data low), then each stored character in arrival
// order (is_data high), with last_of_run high on the final write. Zero bytes
// are dropped. A nonzero byte arriving with the store at its limit (the
// smaller of max_line_length and STORE_DEPTH) discards the line silently.
// An ordinary byte is accepted while the block is idle and the next byte may
// follow at once. A terminator holds off input for the whole run, plus any
// stalls on the result side: the command is loaded first, then each character
// needs a read on the single read port of the line store, then a load of the
// output register. The output register lets a finished request wait without
// blocking the store read.
// The line store has no reset; it is only ever read below the fill count.
// Settings may be written only while the block is idle.
module terminated_line_to_char_lcd_core import tllcd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tllcd_in_if.sink                   in_ch,
  tllcd_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  tllcd_cmd_t cmd;
  tllcd_sts_t sts;

  // Sequencer: idle capture, then command, then read/load per character
  tllcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage, settings and the output register
  tllcd_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_ch.valid),
    .in_rx_byte      (in_ch.rx_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_is_data     (out_ch.is_data),
    .out_lcd_value   (out_ch.lcd_value),
    .out_last_of_run (out_ch.last_of_run)
  );

  // Take input only while no display run is in progress
  assign in_ch.ready = cmd.accept_en;

endmodule

`default_nettype wire
